/* rtl/bal_pkg.sv */
// package with transaction types, codes and helpers for the buddy allocator
package bal_pkg;

	localparam int SIZE_W = 13;
	localparam int OFFS_W = 13;
	localparam int STAT_W = 2;
	localparam int NORD_W = 4;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_TOO_LARGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd2;
	localparam logic [STAT_W-1:0] ST_BAD_FREE  = 2'd3;

	typedef struct packed {
		logic              command;
		logic [SIZE_W-1:0] request_size;
		logic [OFFS_W-1:0] block_offset;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [OFFS_W-1:0] result_offset;
	} rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_START, S_A_RD, S_A_EV, S_A_SPLIT2,
		S_F_RD, S_F_EV, S_F_CHK, S_F_BEV, S_F_MERGE2, S_RESP
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_CLR, OP_LOAD, OP_READ_POS, OP_READ_BUD, OP_STEP,
		OP_WR_ALLOC, OP_SPLIT1, OP_SPLIT2, OP_WR_FREE, OP_MERGE1, OP_MERGE2
	} op_t;

	typedef struct packed {
		op_t               op;
		logic              emit;
		logic [STAT_W-1:0] status;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_free;
		logic alloc_bad;
		logic free_bad_pre;
		logic rd_empty;
		logic rd_skip;
		logic rd_fit;
		logic step_end;
		logic free_bad_hdr;
		logic merge_stop;
		logic bud_ok;
	} stat_t;

	// block order needed for a size, header byte included
	function automatic logic [NORD_W-1:0] size_order(input logic [SIZE_W-1:0] size);
		logic [NORD_W-1:0] n;
		n = NORD_W'(1);
		for (int i = 1; i < SIZE_W; i++) begin
			if (size[i]) begin
				n = NORD_W'(i + 1);
			end
		end
		return n;
	endfunction

endpackage

/* rtl/bal_ctrl.sv */
// controller state machine of the buddy allocator
module bal_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  bal_pkg::stat_t st,
	output bal_pkg::cmd_t  cmd
);

	bal_pkg::state_t state_q, state_d;
	logic [bal_pkg::STAT_W-1:0] status_q, status_d;
	logic out_valid_q;
	logic slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		case (state_q)
			bal_pkg::S_CLEAR: begin
				if (st.clr_last) state_d = bal_pkg::S_IDLE;
			end
			bal_pkg::S_IDLE: begin
				if (in_valid) state_d = bal_pkg::S_START;
			end
			bal_pkg::S_START: begin
				if (st.is_free) begin
					if (st.free_bad_pre) begin
						state_d  = bal_pkg::S_RESP;
						status_d = bal_pkg::ST_BAD_FREE;
					end else begin
						state_d = bal_pkg::S_F_RD;
					end
				end else if (st.alloc_bad) begin
					state_d  = bal_pkg::S_RESP;
					status_d = bal_pkg::ST_TOO_LARGE;
				end else begin
					state_d = bal_pkg::S_A_RD;
				end
			end
			bal_pkg::S_A_RD: state_d = bal_pkg::S_A_EV;
			bal_pkg::S_A_EV: begin
				if (st.rd_empty) begin
					state_d  = bal_pkg::S_RESP;
					status_d = bal_pkg::ST_NO_SPACE;
				end else if (st.rd_skip) begin
					if (st.step_end) begin
						state_d  = bal_pkg::S_RESP;
						status_d = bal_pkg::ST_NO_SPACE;
					end else begin
						state_d = bal_pkg::S_A_RD;
					end
				end else if (st.rd_fit) begin
					state_d  = bal_pkg::S_RESP;
					status_d = bal_pkg::ST_OK;
				end else begin
					state_d = bal_pkg::S_A_SPLIT2;
				end
			end
			bal_pkg::S_A_SPLIT2: state_d = bal_pkg::S_A_RD;
			bal_pkg::S_F_RD: state_d = bal_pkg::S_F_EV;
			bal_pkg::S_F_EV: begin
				if (st.free_bad_hdr) begin
					state_d  = bal_pkg::S_RESP;
					status_d = bal_pkg::ST_BAD_FREE;
				end else begin
					state_d = bal_pkg::S_F_CHK;
				end
			end
			bal_pkg::S_F_CHK: begin
				if (st.merge_stop) begin
					state_d  = bal_pkg::S_RESP;
					status_d = bal_pkg::ST_OK;
				end else begin
					state_d = bal_pkg::S_F_BEV;
				end
			end
			bal_pkg::S_F_BEV: begin
				if (!st.bud_ok) begin
					state_d  = bal_pkg::S_RESP;
					status_d = bal_pkg::ST_OK;
				end else begin
					state_d = bal_pkg::S_F_MERGE2;
				end
			end
			bal_pkg::S_F_MERGE2: state_d = bal_pkg::S_F_CHK;
			bal_pkg::S_RESP: begin
				if (slot_free) state_d = bal_pkg::S_IDLE;
			end
			default: state_d = bal_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.op     = bal_pkg::OP_NONE;
		cmd.emit   = 1'b0;
		cmd.status = status_q;
		case (state_q)
			bal_pkg::S_CLEAR: cmd.op = bal_pkg::OP_CLR;
			bal_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = bal_pkg::OP_LOAD;
			end
			bal_pkg::S_A_RD: cmd.op = bal_pkg::OP_READ_POS;
			bal_pkg::S_A_EV: begin
				if (st.rd_empty) cmd.op = bal_pkg::OP_NONE;
				else if (st.rd_skip) cmd.op = bal_pkg::OP_STEP;
				else if (st.rd_fit) cmd.op = bal_pkg::OP_WR_ALLOC;
				else cmd.op = bal_pkg::OP_SPLIT1;
			end
			bal_pkg::S_A_SPLIT2: cmd.op = bal_pkg::OP_SPLIT2;
			bal_pkg::S_F_RD: cmd.op = bal_pkg::OP_READ_POS;
			bal_pkg::S_F_EV: begin
				if (!st.free_bad_hdr) cmd.op = bal_pkg::OP_WR_FREE;
			end
			bal_pkg::S_F_CHK: begin
				if (!st.merge_stop) cmd.op = bal_pkg::OP_READ_BUD;
			end
			bal_pkg::S_F_BEV: begin
				if (st.bud_ok) cmd.op = bal_pkg::OP_MERGE1;
			end
			bal_pkg::S_F_MERGE2: cmd.op = bal_pkg::OP_MERGE2;
			bal_pkg::S_RESP: cmd.emit = slot_free;
			default: cmd.op = bal_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bal_pkg::S_CLEAR;
			status_q    <= bal_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

/* rtl/bal_dp.sv */
// datapath of the buddy allocator: header memory, walk position and result register
module bal_dp #(
	parameter int HEAP_ORDER  = 13,
	parameter int MAX_REQUEST = 4095
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bal_pkg::req_t in_data,
	input  bal_pkg::cmd_t cmd,
	output bal_pkg::stat_t st,
	output bal_pkg::rsp_t  out_data
);

	localparam int OW    = $clog2(HEAP_ORDER + 1);
	localparam int HW    = OW + 2;
	localparam int AW    = HEAP_ORDER - 1;
	localparam int PW    = HEAP_ORDER + 1;
	localparam int DEPTH = 1 << AW;

	logic [HW-1:0] mem [DEPTH];
	logic [HW-1:0] rdata_q;
	logic [AW-1:0] clr_q;
	logic          cmd_q;
	logic [bal_pkg::NORD_W-1:0] n_q;
	logic [PW-1:0] pos_q;
	logic [HW-1:0] cur_q;
	bal_pkg::rsp_t out_q;
	logic          alloc_bad_q, free_bad_q;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [HW-1:0] wdata;

	logic [OW-1:0] rd_ord, rd_half, cur_ord, cur_up;
	logic [PW-1:0] rd_step, half_step, cur_step, bud, base, other, step_sum;
	logic          cur_left, new_left;
	logic [HW-1:0] merged;
	logic [bal_pkg::NORD_W-1:0] n_in;

	function automatic logic [AW-1:0] step_half_addr(input logic [PW-1:0] p,
			input logic [PW-1:0] s);
		logic [PW-1:0] t;
		t = p + s;
		return t[HEAP_ORDER-1:1];
	endfunction

	assign n_in      = bal_pkg::size_order(in_data.request_size);
	assign rd_ord    = rdata_q[HW-1:2];
	assign rd_half   = rd_ord - OW'(1);
	assign rd_step   = PW'(1) << rd_ord;
	assign half_step = PW'(1) << rd_half;
	assign step_sum  = pos_q + rd_step;
	assign cur_ord   = cur_q[HW-1:2];
	assign cur_up    = cur_ord + OW'(1);
	assign cur_left  = cur_q[1];
	assign cur_step  = PW'(1) << cur_ord;
	assign bud       = cur_left ? (pos_q + cur_step) : (pos_q - cur_step);
	assign base      = cur_left ? pos_q : bud;
	assign other     = cur_left ? bud : pos_q;
	assign new_left  = ((base >> cur_up) & PW'(1)) == '0;
	assign merged    = {cur_up, new_left, 1'b0};

	always_comb begin
		st.clr_last     = &clr_q;
		st.is_free      = cmd_q == bal_pkg::CMD_FREE;
		st.rd_empty     = rd_ord == '0 || 32'(rd_ord) > 32'(HEAP_ORDER);
		st.rd_skip      = rdata_q[0] || 32'(n_q) > 32'(rd_ord);
		st.rd_fit       = 32'(n_q) == 32'(rd_ord);
		st.step_end     = step_sum[HEAP_ORDER];
		st.free_bad_hdr = rdata_q == '0 || !rdata_q[0];
		st.merge_stop   = cur_ord == '0 || 32'(cur_ord) >= 32'(HEAP_ORDER) ||
			(!cur_left && pos_q < cur_step) || (cur_left && bud[HEAP_ORDER]);
		st.bud_ok       = !rdata_q[0] && rd_ord == cur_ord;
		st.alloc_bad    = alloc_bad_q;
		st.free_bad_pre = free_bad_q;
	end

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = pos_q[HEAP_ORDER-1:1];
		raddr = pos_q[HEAP_ORDER-1:1];
		wdata = '0;
		case (cmd.op)
			bal_pkg::OP_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = (clr_q == '0) ? {OW'(HEAP_ORDER), 2'b10} : '0;
			end
			bal_pkg::OP_READ_POS: re = 1'b1;
			bal_pkg::OP_READ_BUD: begin
				re    = 1'b1;
				raddr = bud[HEAP_ORDER-1:1];
			end
			bal_pkg::OP_WR_ALLOC: begin
				we    = 1'b1;
				wdata = rdata_q | HW'(1);
			end
			bal_pkg::OP_SPLIT1: begin
				we    = 1'b1;
				wdata = {rd_half, 2'b10};
			end
			bal_pkg::OP_SPLIT2: begin
				we    = 1'b1;
				waddr = step_half_addr(pos_q, half_step);
				wdata = {rd_half, 2'b00};
			end
			bal_pkg::OP_WR_FREE: begin
				we    = 1'b1;
				wdata = rdata_q & ~HW'(1);
			end
			bal_pkg::OP_MERGE1: begin
				we    = 1'b1;
				waddr = base[HEAP_ORDER-1:1];
				wdata = merged;
			end
			bal_pkg::OP_MERGE2: begin
				we    = 1'b1;
				waddr = other[HEAP_ORDER-1:1];
				wdata = '0;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.op == bal_pkg::OP_CLR) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			bal_pkg::OP_LOAD: begin
				cmd_q       <= in_data.command;
				n_q         <= n_in;
				alloc_bad_q <= 32'(in_data.request_size) > 32'(MAX_REQUEST) ||
					32'(n_in) > 32'(HEAP_ORDER);
				free_bad_q  <= in_data.block_offset == '0 ||
					32'(in_data.block_offset) >= (32'(1) << HEAP_ORDER) ||
					!in_data.block_offset[0];
				if (in_data.command == bal_pkg::CMD_FREE)
					pos_q <= PW'(in_data.block_offset - bal_pkg::OFFS_W'(1));
				else
					pos_q <= '0;
			end
			bal_pkg::OP_STEP:    pos_q <= step_sum;
			bal_pkg::OP_WR_FREE: cur_q <= rdata_q & ~HW'(1);
			bal_pkg::OP_MERGE2: begin
				pos_q <= base;
				cur_q <= merged;
			end
			default: cur_q <= cur_q;
		endcase
		if (cmd.emit) begin
			out_q.status <= cmd.status;
			out_q.result_offset <= (cmd.status == bal_pkg::ST_OK && !cmd_q) ?
				bal_pkg::OFFS_W'(pos_q + PW'(1)) : '0;
		end
	end

	assign out_data = out_q;

endmodule

/* rtl/buddy_allocator_unit.sv */
// top level of the buddy allocator
// Buddy allocator over a heap of 2^HEAP_ORDER bytes with one header per even byte offset
// held in a single-port-style memory (one write and one registered read a cycle). After
// reset a clearing pass writes every header before the first transaction is taken. An
// allocate reads the header at the walk position and then steps past that block, splits
// it or claims it; a free reads and releases its header, then reads each buddy header
// and merges while the buddy is free and of the same order. One transaction is in work
// at a time; its result waits in an output register while the next transaction is
// accepted.
module buddy_allocator_unit #(
	parameter int HEAP_ORDER  = 13,
	parameter int MAX_REQUEST = 4095
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bal_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output bal_pkg::rsp_t out_data
);

	bal_pkg::cmd_t  cmd;
	bal_pkg::stat_t st;

	bal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	bal_dp #(
		.HEAP_ORDER  (HEAP_ORDER),
		.MAX_REQUEST (MAX_REQUEST)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.st       (st),
		.out_data (out_data)
	);

endmodule
